@@ rtl/core/csg_pkg.sv @@
// Package for the cube-map sky gradient block.
// Holds field widths, register indexes, reset colours and the pipeline tag type.
// Used by the channel interfaces, the ratio unit and the top level.
package csg_pkg;

   localparam int FACE_W   = 3;
   localparam int POS_W    = 10;
   localparam int CHAN_W   = 16;
   localparam int COLOUR_W = 48;
   localparam int SIZE_W   = 11;
   localparam int CSR_IDX_W = 2;

   localparam int MAX_FACE_SIZE_DEF = 1024;

   localparam logic [CSR_IDX_W-1:0] REG_ZENITH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HORIZON = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GROUND  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SIZE    = 2'd3;

   localparam logic [COLOUR_W-1:0] ZENITH_RESET  = 48'd84445284781261;
   localparam logic [COLOUR_W-1:0] HORIZON_RESET = 48'd225184491172659;
   localparam logic [COLOUR_W-1:0] GROUND_RESET  = 48'd98519248355328;
   localparam logic [SIZE_W-1:0]   SIZE_RESET    = 11'd128;
   localparam logic [SIZE_W-1:0]   MIN_SIZE      = 11'd4;

   localparam logic [FACE_W-1:0] FACE_POS_X = 3'd0;
   localparam logic [FACE_W-1:0] FACE_NEG_X = 3'd1;
   localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd2;
   localparam logic [FACE_W-1:0] FACE_NEG_Y = 3'd3;
   localparam logic [FACE_W-1:0] FACE_POS_Z = 3'd4;
   localparam logic [FACE_W-1:0] FACE_NEG_Z = 3'd5;

   // quotient of 2^32*p^2/s never exceeds 2^32
   localparam int QUO_W  = 33;
   localparam int ROOT_W = 17;
   localparam int K_W    = 16;
   localparam logic [K_W-1:0] K_ONE = 16'd32768;
   localparam logic [K_W-1:0] K_MAX = 16'd32767;

   typedef struct packed {
      logic valid;
      logic up;
   } tag_type;

endpackage

@@ rtl/core/csg_req_if.sv @@
// Request channel of the cube-map sky gradient block: face and texel position.
// Depends on csg_pkg for field widths.
interface csg_req_if;
   logic                          valid;
   logic                          ready;
   logic [csg_pkg::FACE_W-1:0]    face;
   logic [csg_pkg::POS_W-1:0]     column;
   logic [csg_pkg::POS_W-1:0]     row;

   modport source  (output valid, face, column, row, input ready);
   modport sink    (input valid, face, column, row, output ready);
   modport monitor (input valid, ready, face, column, row);
endinterface

@@ rtl/core/csg_rsp_if.sv @@
// Response channel of the cube-map sky gradient block: one texel colour.
// Depends on csg_pkg for field widths.
interface csg_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [csg_pkg::CHAN_W-1:0]    red;
   logic [csg_pkg::CHAN_W-1:0]    green;
   logic [csg_pkg::CHAN_W-1:0]    blue;

   modport source  (output valid, red, green, blue, input ready);
   modport sink    (input valid, red, green, blue, output ready);
   modport monitor (input valid, ready, red, green, blue);
endinterface

@@ rtl/core/csg_ratio.sv @@
// Pipelined ratio unit: root = isqrt(floor(2^32 * p2 / s)), one bit per stage.
// A restoring divider of 33 stages feeds a digit-by-digit square root of 17 stages.
// Depends on csg_pkg for the tag type and widths.
module csg_ratio #(
   parameter int SW = 23
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             enable,
   input  csg_pkg::tag_type                 tag_i,
   input  logic [SW-1:0]                    p2_i,
   input  logic [SW-1:0]                    s_i,
   output csg_pkg::tag_type                 tag_o,
   output logic [csg_pkg::ROOT_W-1:0]       root_o
);
   localparam int QW = csg_pkg::QUO_W;
   localparam int RTW = csg_pkg::ROOT_W;
   localparam int XW = 2 * RTW;
   localparam int RW = RTW + 3;

   csg_pkg::tag_type  dtag_ff  [0:QW];
   logic [SW:0]       drem_ff  [0:QW];
   logic [SW-1:0]     dsor_ff  [0:QW];
   logic [QW-1:0]     dquo_ff  [0:QW];

   csg_pkg::tag_type  rtag_ff  [1:RTW];
   logic [RW-1:0]     rrem_ff  [1:RTW];
   logic [RTW-1:0]    rroot_ff [1:RTW];
   logic [XW-1:0]     rx_ff    [1:RTW];

   always_ff @(posedge clock) begin
      if (reset) begin
         dtag_ff[0] <= '0;
      end else if (enable) begin
         dtag_ff[0] <= tag_i;
      end
      if (enable) begin
         drem_ff[0] <= {1'b0, p2_i};
         dsor_ff[0] <= s_i;
         dquo_ff[0] <= '0;
      end
   end

   for (genvar i = 0; i < QW; i++) begin : g_div
      logic [SW:0] trial_in;
      logic [SW:0] rem_in;
      logic        bit_in;
      always_comb begin
         if (i == 0) trial_in = drem_ff[i];
         else trial_in = {drem_ff[i][SW-1:0], 1'b0};
         bit_in = (trial_in >= {1'b0, dsor_ff[i]});
         rem_in = bit_in ? trial_in - {1'b0, dsor_ff[i]} : trial_in;
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            dtag_ff[i+1] <= '0;
         end else if (enable) begin
            dtag_ff[i+1] <= dtag_ff[i];
         end
         if (enable) begin
            drem_ff[i+1] <= rem_in;
            dsor_ff[i+1] <= dsor_ff[i];
            dquo_ff[i+1] <= {dquo_ff[i][QW-2:0], bit_in};
         end
      end
   end

   for (genvar j = 0; j < RTW; j++) begin : g_sqrt
      csg_pkg::tag_type src_tag;
      logic [RW-1:0]    src_rem;
      logic [RTW-1:0]   src_root;
      logic [XW-1:0]    src_x;
      logic [RW-1:0]    srem;
      logic [RW-1:0]    strial;
      logic             sbit;
      if (j == 0) begin : g_head
         assign src_tag  = dtag_ff[QW];
         assign src_rem  = '0;
         assign src_root = '0;
         assign src_x    = {{(XW-QW){1'b0}}, dquo_ff[QW]};
      end else begin : g_body
         assign src_tag  = rtag_ff[j];
         assign src_rem  = rrem_ff[j];
         assign src_root = rroot_ff[j];
         assign src_x    = rx_ff[j];
      end
      always_comb begin
         srem   = {src_rem[RW-3:0], src_x[XW-1:XW-2]};
         strial = {1'b0, src_root, 2'b01};
         sbit   = (srem >= strial);
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            rtag_ff[j+1] <= '0;
         end else if (enable) begin
            rtag_ff[j+1] <= src_tag;
         end
         if (enable) begin
            rrem_ff[j+1]  <= sbit ? srem - strial : srem;
            rroot_ff[j+1] <= {src_root[RTW-2:0], sbit};
            rx_ff[j+1]    <= {src_x[XW-3:0], 2'b00};
         end
      end
   end

   assign tag_o  = rtag_ff[RTW];
   assign root_o = rroot_ff[RTW];

   a_div_rem_below: assert property (@(posedge clock) disable iff (reset)
      dtag_ff[QW].valid |-> drem_ff[QW] < {1'b0, dsor_ff[QW]})
      else $error("divider remainder not below divisor");
   a_root_range: assert property (@(posedge clock) disable iff (reset)
      tag_o.valid |-> root_o <= 17'd65536)
      else $error("root out of range");
   a_sqrt_rem_bound: assert property (@(posedge clock) disable iff (reset)
      tag_o.valid |-> rrem_ff[RTW] <= {2'b00, root_o, 1'b0})
      else $error("square root remainder too large");
endmodule

@@ rtl/core/cubemap_sky_gradient.sv @@
// Top level of the cube-map sky gradient block.
// Uses csg_pkg, csg_req_if, csg_rsp_if and the csg_ratio pipeline.
//
// Usage:
//   req carries one word per texel: face (0 +X .. 5 -Z), column and row.
//   rsp returns one word per request, in order: red, green, blue (Q0.16).
//   csr_we/csr_index/csr_data write zenith, horizon, ground colour and face
//   size; write only while no request is in flight.
//   Throughput: one word per cycle while rsp.ready is not held low. From
//   accept to rsp.valid a word passes five front stages, the ratio unit (an
//   input register, a 33-stage divider and a 17-stage square root, one
//   result bit per stage) and three blend stages. Reset clears all valid
//   bits and loads the default colours and face size 128. When the
//   receiver holds rsp.ready low with a word waiting, the whole pipeline
//   holds and req.ready drops in the same cycle; nothing is lost or
//   repeated. Face 6 and 7 return the horizon colour.
module cubemap_sky_gradient #(
   parameter int MAX_FACE_SIZE = csg_pkg::MAX_FACE_SIZE_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   csg_req_if.sink                            req,
   csg_rsp_if.source                          rsp,
   input  logic                               csr_we,
   input  logic [csg_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [csg_pkg::COLOUR_W-1:0]       csr_data
);
   localparam int NW = $clog2(MAX_FACE_SIZE + 1);
   localparam int CW = (NW > csg_pkg::SIZE_W) ? NW : csg_pkg::SIZE_W;
   localparam int DW = NW + 2;
   localparam int SW = 2 * NW + 1;
   localparam int CH = csg_pkg::CHAN_W;
   localparam int KW = csg_pkg::K_W;
   localparam logic [CW-1:0] MAX_N = CW'(MAX_FACE_SIZE);

   logic [csg_pkg::COLOUR_W-1:0] zenith_ff, horizon_ff, ground_ff;
   logic [csg_pkg::SIZE_W-1:0]   size_ff;

   logic enable;
   logic out_valid_ff;

   csg_pkg::tag_type              t1_ff, t2_ff, t3_ff, t4_ff, tr, t6_ff, t7_ff;
   logic [csg_pkg::FACE_W-1:0]    face1_ff, face2_ff;
   logic [csg_pkg::POS_W-1:0]     col1_ff, row1_ff, col2_ff, row2_ff;
   logic [NW-1:0]                 n2_ff, n3_ff;
   logic [DW-1:0]                 du3_ff, dv3_ff, p3_ff;
   logic [SW-1:0]                 nn4_ff, uu4_ff, vv4_ff, pp4_ff;
   logic [SW-1:0]                 s5_ff, pp5_ff;
   logic [csg_pkg::ROOT_W-1:0]    root;
   logic [KW-1:0]                 k6_ff;
   logic [2*CH-1:0]               ph7_ff [0:2];
   logic [2*CH-1:0]               pg7_ff [0:2];
   logic [CH-1:0]                 out_ff [0:2];

   logic [CW-1:0]   fs_ext, n_in;
   logic [CW-1:0]   col_ext, row_ext, nm1;
   logic [NW-1:0]   colc, rowc;
   logic [DW-1:0]   a_in, b_in, n_d, du_in, dv_in, p_in;
   logic            up_in;
   logic [DW-1:0]   du_abs, dv_abs, p_abs, n_abs;
   logic [csg_pkg::ROOT_W:0] r_inc;
   logic [KW-1:0]   k_in;
   logic [csg_pkg::COLOUR_W-1:0] target;

   assign enable    = !out_valid_ff || rsp.ready;
   assign req.ready = enable;

   always_ff @(posedge clock) begin
      if (reset) begin
         zenith_ff  <= csg_pkg::ZENITH_RESET;
         horizon_ff <= csg_pkg::HORIZON_RESET;
         ground_ff  <= csg_pkg::GROUND_RESET;
         size_ff    <= csg_pkg::SIZE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            csg_pkg::REG_ZENITH:  zenith_ff  <= csr_data;
            csg_pkg::REG_HORIZON: horizon_ff <= csr_data;
            csg_pkg::REG_GROUND:  ground_ff  <= csr_data;
            csg_pkg::REG_SIZE:    size_ff    <= csr_data[csg_pkg::SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp face size
   always_comb begin
      fs_ext = CW'(size_ff);
      if (fs_ext < CW'(csg_pkg::MIN_SIZE)) n_in = CW'(csg_pkg::MIN_SIZE);
      else if (fs_ext > MAX_N) n_in = MAX_N;
      else n_in = fs_ext;
   end

   // clamp position, form centered offsets and the vertical numerator
   always_comb begin
      col_ext = CW'(col2_ff);
      row_ext = CW'(row2_ff);
      nm1     = CW'(n2_ff) - CW'(1);
      colc    = NW'((col_ext > nm1) ? nm1 : col_ext);
      rowc    = NW'((row_ext > nm1) ? nm1 : row_ext);
      a_in    = {1'b0, colc, 1'b1};
      b_in    = {1'b0, rowc, 1'b1};
      n_d     = DW'(n2_ff);
      du_in   = a_in - n_d;
      dv_in   = b_in - n_d;
      case (face2_ff)
         csg_pkg::FACE_POS_Y: p_in = n_d;
         csg_pkg::FACE_NEG_Y: p_in = -n_d;
         csg_pkg::FACE_POS_X, csg_pkg::FACE_NEG_X,
         csg_pkg::FACE_POS_Z, csg_pkg::FACE_NEG_Z: p_in = n_d - b_in;
         default: p_in = '0;
      endcase
      up_in = !p_in[DW-1];
   end

   always_comb begin
      du_abs = du3_ff[DW-1] ? -du3_ff : du3_ff;
      dv_abs = dv3_ff[DW-1] ? -dv3_ff : dv3_ff;
      p_abs  = p3_ff[DW-1] ? -p3_ff : p3_ff;
      n_abs  = DW'(n3_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_ff <= '0;
         t2_ff <= '0;
         t3_ff <= '0;
         t4_ff <= '0;
      end else if (enable) begin
         t1_ff <= '{valid: req.valid, up: 1'b0};
         t2_ff <= t1_ff;
         t3_ff <= '{valid: t2_ff.valid, up: up_in};
         t4_ff <= t3_ff;
      end
      if (enable) begin
         face1_ff <= req.face;
         col1_ff  <= req.column;
         row1_ff  <= req.row;
         face2_ff <= face1_ff;
         col2_ff  <= col1_ff;
         row2_ff  <= row1_ff;
         n2_ff    <= NW'(n_in);
         n3_ff    <= n2_ff;
         du3_ff   <= du_in;
         dv3_ff   <= dv_in;
         p3_ff    <= p_in;
         nn4_ff   <= SW'(n_abs) * SW'(n_abs);
         uu4_ff   <= SW'(du_abs) * SW'(du_abs);
         vv4_ff   <= SW'(dv_abs) * SW'(dv_abs);
         pp4_ff   <= SW'(p_abs) * SW'(p_abs);
         s5_ff    <= nn4_ff + uu4_ff + vv4_ff;
         pp5_ff   <= pp4_ff;
      end
   end

   csg_pkg::tag_type t5_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         t5_ff <= '0;
      end else if (enable) begin
         t5_ff <= t4_ff;
      end
   end

   csg_ratio #(.SW(SW)) u_ratio (
      .clock  (clock),
      .reset  (reset),
      .enable (enable),
      .tag_i  (t5_ff),
      .p2_i   (pp5_ff),
      .s_i    (s5_ff),
      .tag_o  (tr),
      .root_o (root)
   );

   always_comb begin
      r_inc = {1'b0, root} + 18'd1;
      k_in  = KW'(r_inc[csg_pkg::ROOT_W:1]);
      if (tr.up && k_in > csg_pkg::K_MAX) k_in = csg_pkg::K_MAX;
      target = t6_ff.up ? zenith_ff : ground_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t6_ff        <= '0;
         t7_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else if (enable) begin
         t6_ff        <= tr;
         t7_ff        <= t6_ff;
         out_valid_ff <= t7_ff.valid;
      end
      if (enable) begin
         k6_ff <= k_in;
      end
   end

   for (genvar c = 0; c < 3; c++) begin : g_chan
      localparam int SH = 2 * CH - CH * c;
      logic [2*CH-1:0] mix;
      assign mix = ph7_ff[c] + pg7_ff[c] + 32'd16384;
      always_ff @(posedge clock) begin
         if (enable) begin
            ph7_ff[c] <= horizon_ff[SH +: CH] * (csg_pkg::K_ONE - k6_ff);
            pg7_ff[c] <= target[SH +: CH] * k6_ff;
            out_ff[c] <= mix[30:15];
         end
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.red   = out_ff[0];
   assign rsp.green = out_ff[1];
   assign rsp.blue  = out_ff[2];

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp.ready) |-> !req.ready)
      else $error("input accepted while output stalled");
   a_k_range: assert property (@(posedge clock) disable iff (reset)
      t6_ff.valid |-> k6_ff <= csg_pkg::K_ONE)
      else $error("blend weight above one");
   a_up_saturates: assert property (@(posedge clock) disable iff (reset)
      (t6_ff.valid && t6_ff.up) |-> k6_ff <= csg_pkg::K_MAX)
      else $error("upward weight not saturated");
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp.valid)
      else $error("output valid after reset");
endmodule

@@ verif/csg_checker.sv @@
// Checker for the cube-map sky gradient block: watches the request, response and
// register-write ports, predicts each texel colour and compares it field by field.
// Depends on csg_pkg and the csg_req_if / csg_rsp_if interfaces.
module csg_checker (
   input  logic                          clock,
   input  logic                          reset,
   csg_req_if.monitor                    req,
   csg_rsp_if.monitor                    rsp,
   input  logic                          csr_we,
   input  logic [csg_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [csg_pkg::COLOUR_W-1:0]  csr_data,
   output int                            fail_count,
   output int                            pending_texels
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [csg_pkg::CHAN_W-1:0] red;
      logic [csg_pkg::CHAN_W-1:0] green;
      logic [csg_pkg::CHAN_W-1:0] blue;
   } texel_type;

   logic [csg_pkg::COLOUR_W-1:0] zenith_q, horizon_q, ground_q;
   logic [csg_pkg::SIZE_W-1:0]   size_q;
   texel_type                    texel_q[$];

   function automatic logic [15:0] blend_weight(longint unsigned p, longint unsigned s);
      longint unsigned rhs, c, d;
      logic [15:0] q;
      int bitpos;
      rhs = (64'd65536 * p) * (64'd65536 * p);
      q = 0;
      for (bitpos = 15; bitpos >= 0; bitpos--) begin
         c = longint'(q) + (64'd1 << bitpos);
         d = 2 * c - 1;
         if (d * d * s <= rhs) q = c[15:0];
      end
      return q;
   endfunction

   function automatic texel_type sky_texel(logic [csg_pkg::FACE_W-1:0] face,
                                           logic [csg_pkg::POS_W-1:0] column,
                                           logic [csg_pkg::POS_W-1:0] row);
      longint n, col, rw, a, b, du, dv, p, h, g;
      longint unsigned s;
      logic [15:0] k;
      logic up;
      logic [csg_pkg::COLOUR_W-1:0] target;
      logic [csg_pkg::CHAN_W-1:0] ch[3];
      n = size_q;
      if (n < 4) n = 4;
      if (n > csg_pkg::MAX_FACE_SIZE_DEF) n = csg_pkg::MAX_FACE_SIZE_DEF;
      col = column;
      rw = row;
      if (col > n - 1) col = n - 1;
      if (rw > n - 1) rw = n - 1;
      a = 2 * col + 1;
      b = 2 * rw + 1;
      du = a - n;
      dv = b - n;
      s = n * n + du * du + dv * dv;
      if (face == csg_pkg::FACE_POS_Y) p = n;
      else if (face == csg_pkg::FACE_NEG_Y) p = -n;
      else if (face <= csg_pkg::FACE_NEG_Z) p = n - b;
      else p = 0;
      up = (p >= 0);
      k = blend_weight(p < 0 ? -p : p, s);
      if (up && k > csg_pkg::K_MAX) k = csg_pkg::K_MAX;
      target = up ? zenith_q : ground_q;
      for (int i = 0; i < 3; i++) begin
         h = horizon_q[32 - 16 * i +: 16];
         g = target[32 - 16 * i +: 16];
         ch[i] = 16'((h * (32768 - k) + g * k + 16384) >> 15);
      end
      return '{ch[0], ch[1], ch[2]};
   endfunction

   always @(posedge clock) begin
      texel_type want;
      if (reset) begin
         zenith_q <= csg_pkg::ZENITH_RESET;
         horizon_q <= csg_pkg::HORIZON_RESET;
         ground_q <= csg_pkg::GROUND_RESET;
         size_q <= csg_pkg::SIZE_RESET;
         texel_q.delete();
         fail_count <= 0;
      end else begin
         if (req.valid && req.ready) texel_q.push_back(sky_texel(req.face, req.column, req.row));
         if (rsp.valid && rsp.ready) begin
            if (texel_q.size() == 0) begin
               $error("unexpected texel %h %h %h", rsp.red, rsp.green, rsp.blue);
               fail_count <= fail_count + 1;
            end else begin
               want = texel_q.pop_front();
               if (rsp.red !== want.red)
                  $error("red: expected %h, actual %h", want.red, rsp.red);
               if (rsp.green !== want.green)
                  $error("green: expected %h, actual %h", want.green, rsp.green);
               if (rsp.blue !== want.blue)
                  $error("blue: expected %h, actual %h", want.blue, rsp.blue);
               if (rsp.red !== want.red || rsp.green !== want.green || rsp.blue !== want.blue)
                  fail_count <= fail_count + 1;
            end
         end
         if (csr_we) begin
            case (csr_index)
               csg_pkg::REG_ZENITH: zenith_q <= csr_data;
               csg_pkg::REG_HORIZON: horizon_q <= csr_data;
               csg_pkg::REG_GROUND: ground_q <= csr_data;
               csg_pkg::REG_SIZE: size_q <= csr_data[csg_pkg::SIZE_W-1:0];
               default: ;
            endcase
         end
      end
   end

   assign pending_texels = texel_q.size();
endmodule

@@ verif/tb_top.sv @@
// Top of the cube-map sky gradient testbench: clock, reset, register writes,
// request stimulus and response stalls in several idling phases, and the verdict.
// Depends on csg_pkg, the channel interfaces, csg_checker and the block.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT = 600000;
   localparam int FW = csg_pkg::FACE_W;
   localparam int PW = csg_pkg::POS_W;
   localparam int DW = csg_pkg::COLOUR_W;
   localparam int IW = csg_pkg::CSR_IDX_W;

   logic clock = 0;
   logic reset = 1;
   logic csr_we = 0;
   logic [IW-1:0] csr_index = csg_pkg::REG_ZENITH;
   logic [DW-1:0] csr_data = '0;
   int fail_count, pending_texels;
   int send_idle = 0, recv_stall = 0;
   bit hold_off = 0;
   longint cycles = 0;

   csg_req_if req ();
   csg_rsp_if rsp ();

   cubemap_sky_gradient DUT (.clock, .reset, .req(req.sink), .rsp(rsp.source),
                             .csr_we, .csr_index, .csr_data);
   csg_checker u_checker (.clock, .reset, .req(req.monitor), .rsp(rsp.monitor), .csr_we,
                          .csr_index, .csr_data, .fail_count, .pending_texels);

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) rsp.ready <= 0;
      else if (hold_off) rsp.ready <= 0;
      else rsp.ready <= ($urandom_range(99) >= recv_stall);
   end

   task automatic csr_write(logic [IW-1:0] idx, logic [DW-1:0] value);
      csr_we <= 1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_we <= 0;
      @(posedge clock);
   endtask

   task automatic drain();
      req.valid <= 0;
      @(posedge clock);
      while (pending_texels != 0) @(posedge clock);
      repeat (70) @(posedge clock);
   endtask

   task automatic send(logic [FW-1:0] face, logic [PW-1:0] column, logic [PW-1:0] row);
      while ($urandom_range(99) < send_idle) begin
         req.valid <= 0;
         @(posedge clock);
      end
      req.valid <= 1;
      req.face <= face;
      req.column <= column;
      req.row <= row;
      do @(posedge clock); while (!req.ready);
   endtask

   task automatic random_texels(int count, int size);
      int top;
      top = (size < 4) ? 3 : (size > 1024 ? 1023 : size - 1);
      repeat (count) begin
         if ($urandom_range(9) == 0)
            send(FW'($urandom_range(7)), PW'($urandom_range(1023)),
                 PW'($urandom_range(1023)));
         else
            send(FW'($urandom_range(5)), PW'($urandom_range(top)),
                 PW'($urandom_range(top)));
      end
   endtask

   task automatic random_colours();
      csr_write(csg_pkg::REG_ZENITH, DW'({$urandom, $urandom}));
      csr_write(csg_pkg::REG_HORIZON, DW'({$urandom, $urandom}));
      csr_write(csg_pkg::REG_GROUND, DW'({$urandom, $urandom}));
   endtask

   initial begin
      int sizes[8] = '{128, 1, 0, 4, 7, 1024, 2047, 33};
      req.valid <= 0;
      req.face <= '0;
      req.column <= '0;
      req.row <= '0;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: face extremes, clamped positions, unknown faces, centre of +Y
      send(csg_pkg::FACE_POS_X, 10'd0, 10'd0);
      send(csg_pkg::FACE_NEG_X, 10'd127, 10'd127);
      send(csg_pkg::FACE_POS_Y, 10'd64, 10'd64);
      send(csg_pkg::FACE_NEG_Y, 10'd0, 10'd127);
      send(csg_pkg::FACE_POS_Z, 10'd1023, 10'd1023);
      send(csg_pkg::FACE_NEG_Z, 10'd1023, 10'd0);
      send(3'd6, 10'd10, 10'd20);
      send(3'd7, 10'd1023, 10'd1023);
      drain();
      csr_write(csg_pkg::REG_SIZE, 48'd7);
      csr_write(csg_pkg::REG_ZENITH, 48'hFFFF_FFFF_FFFF);
      csr_write(csg_pkg::REG_HORIZON, 48'h0);
      csr_write(csg_pkg::REG_GROUND, 48'hFFFF_0000_FFFF);
      send(csg_pkg::FACE_POS_Y, 10'd3, 10'd3);
      send(csg_pkg::FACE_NEG_Y, 10'd3, 10'd3);
      send(csg_pkg::FACE_POS_X, 10'd6, 10'd0);
      send(csg_pkg::FACE_POS_Z, 10'd0, 10'd6);
      send(csg_pkg::FACE_NEG_X, 10'd1023, 10'd1023);
      drain();
      csr_write(csg_pkg::REG_HORIZON, 48'hFFFF_FFFF_FFFF);
      csr_write(csg_pkg::REG_ZENITH, 48'h0);
      send(csg_pkg::FACE_POS_Y, 10'd3, 10'd3);
      send(csg_pkg::FACE_NEG_Z, 10'd0, 10'd0);
      drain();
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle = 0; recv_stall = 0; end
            1: begin send_idle = 60; recv_stall = 0; end
            2: begin send_idle = 0; recv_stall = 60; end
            default: begin send_idle = 31; recv_stall = 31; end
         endcase
         random_colours();
         csr_write(csg_pkg::REG_SIZE, DW'(sizes[ph]));
         if (ph == 4) begin
            fork
               begin
                  hold_off <= 1;
                  repeat (300) @(posedge clock);
                  hold_off <= 0;
               end
               random_texels(160, sizes[ph]);
            join
         end else begin
            random_texels(160, sizes[ph]);
         end
         drain();
      end
      if (fail_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end
endmodule

@@ files.f @@
rtl/core/csg_pkg.sv
rtl/core/csg_req_if.sv
rtl/core/csg_rsp_if.sv
rtl/core/csg_ratio.sv
rtl/core/cubemap_sky_gradient.sv
verif/csg_checker.sv
verif/tb_top.sv
